FILE: hw/rtl/ecr_pkg.sv
package ecr_pkg;

  // span of the wrapping hardware pulse counter is -COUNT_LIMIT..+COUNT_LIMIT
  localparam int COUNT_LIMIT = 1000;

  localparam int SAMPLE_W = 11;
  localparam int TICK_W   = 32;
  localparam int TOTAL_W  = 48;
  localparam int SPEED_W  = 32;
  localparam int CPR_W    = 16;
  localparam int RATE_W   = 14;
  localparam int DATA_W   = 16;

  // 60 s/min times 2^8 for the Q8 speed
  localparam int K_SCALE  = 60 * 256;
  localparam int K_W      = 28;

  // divider datapath
  localparam int DIV_W    = 48;
  localparam int DVD_W    = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
  localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(1);

  typedef enum logic [0:0] {
    CFG_COUNTS_PER_REV = 1'b0,
    CFG_TICK_RATE_HZ   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pulse_sample;
    logic [TICK_W-1:0]          tick_now;
  } in_item_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_count;
    logic signed [TOTAL_W-1:0] rotations_q16;
    logic signed [SPEED_W-1:0] speed_rpm_q8;
  } out_item_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [CPR_W-1:0] cpr;
    logic [K_W-1:0]   k;
  } cfg_t;

endpackage

FILE: hw/rtl/ecr_cfg_regs.sv
module ecr_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  ecr_pkg::cfg_idx_e       cfg_index_i,
  input  logic [ecr_pkg::DATA_W-1:0] cfg_data_i,
  output ecr_pkg::cfg_t           cfg_o
);

  logic [ecr_pkg::CPR_W-1:0]  cpr_q, cpr_d;
  logic [ecr_pkg::RATE_W-1:0] rate_q, rate_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cpr_d  = cpr_q;
    rate_d = rate_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecr_pkg::CFG_COUNTS_PER_REV: cpr_d  = cfg_data_i[ecr_pkg::CPR_W-1:0];
        ecr_pkg::CFG_TICK_RATE_HZ:   rate_d = cfg_data_i[ecr_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= ecr_pkg::CPR_RESET;
      rate_q <= ecr_pkg::RATE_RESET;
    end else begin
      cpr_q  <= cpr_d;
      rate_q <= rate_d;
    end
  end

  // zero counts per rev divides as one
  assign cfg_o.cpr = (cpr_q == '0) ? ecr_pkg::CPR_W'(1) : cpr_q;
  assign cfg_o.k   = ecr_pkg::K_W'(rate_q) * ecr_pkg::K_W'(ecr_pkg::K_SCALE);

endmodule

FILE: hw/rtl/ecr_div_step.sv
module ecr_div_step (
  input  logic [ecr_pkg::DIV_W-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [ecr_pkg::DIV_W-1:0] div_i,
  output logic [ecr_pkg::DIV_W-1:0] rem_o,
  output logic                      q_o
);

  logic [ecr_pkg::DIV_W:0] shifted;
  logic [ecr_pkg::DIV_W:0] trial;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_i, bit_i};
    trial   = shifted - {1'b0, div_i};
    q_o     = ~trial[ecr_pkg::DIV_W];
    rem_o   = q_o ? trial[ecr_pkg::DIV_W-1:0] : shifted[ecr_pkg::DIV_W-1:0];
  end

endmodule

FILE: hw/rtl/encoder_count_extend_rpm_core.sv
// Encoder count extension and speed core. Each transaction on the input side
// carries one reading of the wrapping pulse counter and the current tick; each
// one yields exactly one result with the unwrapped total, rotations in Q16 and
// speed in Q8 RPM. Items are handled one at a time through a single shared
// restoring divider: with the tick unchanged an item runs accumulation,
// preparation and 64 divider steps for the rotations; when the tick moved,
// a low and a high multiply and a sum follow, then 32 divider steps for the
// speed. in_stall_o is high while an item is in work. A finished result
// sits in an output register, so a new item is taken while the last one
// waits downstream. Configuration writes are taken at any time but must
// only be issued while the block is idle.
module encoder_count_extend_rpm_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ecr_pkg::in_item_t          in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ecr_pkg::out_item_t         out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  ecr_pkg::cfg_idx_e          cfg_index_i,
  input  logic [ecr_pkg::DATA_W-1:0] cfg_data_i
);

  localparam int DELTA_W = 18;
  localparam int CNT_W   = 6;
  localparam int TW      = ecr_pkg::TOTAL_W;

  localparam logic signed [DELTA_W-1:0] LIMIT_S = DELTA_W'(ecr_pkg::COUNT_LIMIT);
  localparam logic signed [DELTA_W-1:0] SPAN_S  = DELTA_W'(2 * ecr_pkg::COUNT_LIMIT);
  localparam logic [ecr_pkg::DVD_W-1:0] ROT_NEG_CAP = ecr_pkg::DVD_W'(64'h8000_0000_0000);
  localparam logic [ecr_pkg::DVD_W-1:0] ROT_POS_CAP = ecr_pkg::DVD_W'(64'h7FFF_FFFF_FFFF);
  localparam logic [ecr_pkg::SPEED_W-1:0] SPD_NEG_CAP = 32'h8000_0000;
  localparam logic [ecr_pkg::SPEED_W-1:0] SPD_POS_CAP = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(63);
  localparam logic [CNT_W-1:0] SPD_LAST = CNT_W'(31);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ACC    = 11'b000_0000_0010,
    S_PREP   = 11'b000_0000_0100,
    S_ROT    = 11'b000_0000_1000,
    S_ROTFIN = 11'b000_0001_0000,
    S_MUL_LO = 11'b000_0010_0000,
    S_MUL_HI = 11'b000_0100_0000,
    S_SUM    = 11'b000_1000_0000,
    S_SPD    = 11'b001_0000_0000,
    S_SPDFIN = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  ecr_pkg::cfg_t cfg;

  // control state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // item state
  logic signed [ecr_pkg::SAMPLE_W-1:0] prev_sample_q, prev_sample_d;
  logic signed [TW-1:0]                total_q, total_d;
  logic signed [TW-1:0]                snap_q, snap_d;
  logic [ecr_pkg::TICK_W-1:0]          prev_tick_q, prev_tick_d;
  logic signed [ecr_pkg::SPEED_W-1:0]  held_q, held_d;

  // working registers
  ecr_pkg::in_item_t                   in_q, in_d;
  ecr_pkg::out_item_t                  out_q, out_d;
  logic                                upd_q, upd_d;
  logic signed [TW-1:0]                rot_q, rot_d;
  logic signed [TW:0]                  dc_q, dc_d;
  logic [TW-1:0]                       a_q, a_d;
  logic                                sneg_q, sneg_d;
  logic [ecr_pkg::DVD_W-1:0]           dvd_q, dvd_d;
  logic [ecr_pkg::DIV_W-1:0]           rem_q, rem_d;
  logic [51:0]                         p_lo_q, p_lo_d;
  logic [51:0]                         p_hi_q, p_hi_d;
  logic [ecr_pkg::DIV_W-1:0]           dd_q, dd_d;
  logic                                ovf_q, ovf_d;

  // shared divider step
  logic [ecr_pkg::DIV_W-1:0] step_div;
  logic [ecr_pkg::DIV_W-1:0] step_rem;
  logic                      step_q;

  logic in_xfer;
  logic out_xfer;
  logic slot_free;

  ecr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign step_div = (state_q == S_SPD) ? dd_q : ecr_pkg::DIV_W'(cfg.cpr);

  ecr_div_step u_div_step (
    .rem_i (rem_q),
    .bit_i (dvd_q[ecr_pkg::DVD_W-1]),
    .div_i (step_div),
    .rem_o (step_rem),
    .q_o   (step_q)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    logic signed [DELTA_W-1:0]   delta;
    logic signed [TW:0]          sum;
    logic [TW-1:0]               mag;
    logic [TW:0]                 dc_neg;
    logic [ecr_pkg::DVD_W-1:0]   rot_mag;
    logic [TW-1:0]               rot_sat;
    logic [ecr_pkg::TICK_W-1:0]  dt;
    logic [75:0]                 prod;
    logic [ecr_pkg::SPEED_W-1:0] quo;
    logic [ecr_pkg::SPEED_W-1:0] sp;

    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_xfer ? 1'b0 : out_valid_q;
    prev_sample_d = prev_sample_q;
    total_d       = total_q;
    snap_d        = snap_q;
    prev_tick_d   = prev_tick_q;
    held_d        = held_q;
    in_d          = in_q;
    out_d         = out_q;
    upd_d         = upd_q;
    rot_d         = rot_q;
    dc_d          = dc_q;
    a_d           = a_q;
    sneg_d        = sneg_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    p_lo_d        = p_lo_q;
    p_hi_d        = p_hi_q;
    dd_d          = dd_q;
    ovf_d         = ovf_q;

    delta   = DELTA_W'(in_q.pulse_sample) - DELTA_W'(prev_sample_q);
    sum     = '0;
    mag     = '0;
    dc_neg  = -dc_q;
    rot_mag = '0;
    rot_sat = '0;
    dt      = in_q.tick_now - prev_tick_q;
    prod    = 76'(p_lo_q) + (76'(p_hi_q) << 24);
    quo     = dvd_q[ecr_pkg::SPEED_W-1:0];
    sp      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          in_d    = in_i;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        // unwrap the counter change, then add with saturation
        if (delta > LIMIT_S) begin
          delta = delta - SPAN_S;
        end else if (delta < -LIMIT_S) begin
          delta = delta + SPAN_S;
        end
        sum = (TW+1)'(total_q) + (TW+1)'(delta);
        if (sum[TW] != sum[TW-1]) begin
          total_d = sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
          total_d = sum[TW-1:0];
        end
        prev_sample_d = in_q.pulse_sample;
        upd_d         = (in_q.tick_now != prev_tick_q);
        state_d       = S_PREP;
      end
      S_PREP: begin
        mag     = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
        dvd_d   = {mag, 16'h0};
        rem_d   = '0;
        cnt_d   = '0;
        dc_d    = (TW+1)'(total_q) - (TW+1)'(snap_q);
        state_d = S_ROT;
      end
      S_ROT: begin
        a_d    = dc_q[TW] ? dc_neg[TW-1:0] : dc_q[TW-1:0];
        sneg_d = dc_q[TW];
        rem_d  = step_rem;
        dvd_d  = {dvd_q[ecr_pkg::DVD_W-2:0], step_q};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == ROT_LAST) begin
          state_d = S_ROTFIN;
        end
      end
      S_ROTFIN: begin
        if (total_q[TW-1]) begin
          rot_mag = (dvd_q > ROT_NEG_CAP) ? ROT_NEG_CAP : dvd_q;
        end else begin
          rot_mag = (dvd_q > ROT_POS_CAP) ? ROT_POS_CAP : dvd_q;
        end
        rot_sat = rot_mag[TW-1:0];
        rot_d   = total_q[TW-1] ? -rot_sat : rot_sat;
        state_d = upd_q ? S_MUL_LO : S_DONE;
      end
      S_MUL_LO: begin
        p_lo_d  = 52'(a_q[23:0]) * 52'(cfg.k);
        dd_d    = ecr_pkg::DIV_W'(cfg.cpr) * ecr_pkg::DIV_W'(dt);
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        p_hi_d  = 52'(a_q[TW-1:24]) * 52'(cfg.k);
        state_d = S_SUM;
      end
      S_SUM: begin
        rem_d   = ecr_pkg::DIV_W'(prod[75:32]);
        dvd_d   = {prod[31:0], 32'h0};
        cnt_d   = '0;
        state_d = S_SPD;
      end
      S_SPD: begin
        // quotient of 2^32 or more shows in the upper part before any step
        if (cnt_q == '0) begin
          ovf_d = (rem_q >= dd_q);
        end
        rem_d = step_rem;
        dvd_d = {dvd_q[ecr_pkg::DVD_W-2:0], step_q};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SPD_LAST) begin
          state_d = S_SPDFIN;
        end
      end
      S_SPDFIN: begin
        if (sneg_q) begin
          sp = (ovf_q || quo > SPD_NEG_CAP) ? SPD_NEG_CAP : quo;
        end else begin
          sp = (ovf_q || quo > SPD_POS_CAP) ? SPD_POS_CAP : quo;
        end
        held_d  = sneg_q ? -sp : sp;
        snap_d  = total_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_d.total_count   = total_q;
          out_d.rotations_q16 = rot_q;
          out_d.speed_rpm_q8  = held_q;
          out_valid_d         = 1'b1;
          prev_tick_d         = in_q.tick_now;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      prev_sample_q <= '0;
      total_q       <= '0;
      snap_q        <= '0;
      prev_tick_q   <= '0;
      held_q        <= '0;
      upd_q         <= 1'b0;
      ovf_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      prev_sample_q <= prev_sample_d;
      total_q       <= total_d;
      snap_q        <= snap_d;
      prev_tick_q   <= prev_tick_d;
      held_q        <= held_d;
      upd_q         <= upd_d;
      ovf_q         <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    out_q  <= out_d;
    rot_q  <= rot_d;
    dc_q   <= dc_d;
    a_q    <= a_d;
    sneg_q <= sneg_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    p_lo_q <= p_lo_d;
    p_hi_q <= p_hi_d;
    dd_q   <= dd_d;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_ACC)
    else $error("accepted transaction did not start accumulation");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result presented outside completion");

  a_speed_needs_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> $past(upd_q) && $past(state_q == S_SPDFIN))
    else $error("speed changed without a tick change");

  a_spd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SPD |-> cnt_q <= SPD_LAST)
    else $error("speed division ran past its last step");

endmodule
